[sv/serial_gamepad_poller_unit_macros.svh]
// Assertion shorthands shared by the poller RTL.
`ifndef SERIAL_GAMEPAD_POLLER_UNIT_MACROS_SVH
`define SERIAL_GAMEPAD_POLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SGP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SGP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgp: next-cycle check failed");

`endif

[sv/sgp_pkg.sv]
`default_nettype none

package sgp_pkg;

  // Field and register widths
  localparam int TICK_W     = 20;
  localparam int TIMING_W   = 8;
  localparam int BIT_W      = 5;
  localparam int CODE_W     = 3;
  localparam int MARK_COUNT = 16;
  localparam int MARK_IDX_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 2'd2;

  // Configuration reset values
  localparam logic [TIMING_W-1:0] LATCH_TICKS_RST = 8'd12;
  localparam logic [TIMING_W-1:0] HALF_PERIOD_RST = 8'd6;
  localparam logic [TICK_W-1:0]   HOLDOFF_RST     = 20'd200000;

  // Poll sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LATCH = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_HOLD  = 5'b10000
  } sgp_phase_t;

  typedef struct packed {
    logic [TIMING_W-1:0] latch_ticks;
    logic [TIMING_W-1:0] half_period_ticks;
    logic [TICK_W-1:0]   holdoff_ticks;
  } sgp_cfg_t;

  typedef struct packed {
    logic              busy_res;
    logic              any_pressed;
    logic [CODE_W-1:0] button_code;
    logic              poll_done;
    logic              latch_line;
    logic              clock_line;
  } sgp_result_t;

  // Map a serial bit position to its reported button code
  function automatic logic [CODE_W-1:0] code_of_bit(input logic [BIT_W-1:0] bit_num);
    logic [CODE_W-1:0] code;
    unique case (bit_num)
      5'd4:    code = 3'd6;
      5'd5:    code = 3'd4;
      5'd6:    code = 3'd1;
      5'd7:    code = 3'd2;
      5'd8:    code = 3'd3;
      5'd9:    code = 3'd5;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[sv/sgp_core.sv]
`default_nettype none

`include "serial_gamepad_poller_unit_macros.svh"

module sgp_core #(
  parameter int BUTTON_COUNT = 16,
  parameter int CLOCK_PULSES = 17
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire logic                poll_request,
  input  wire logic                data_line,
  input  wire sgp_pkg::sgp_cfg_t   cfg,
  output sgp_pkg::sgp_result_t     res
);

  localparam logic [sgp_pkg::BIT_W-1:0] BTN_LAST   = sgp_pkg::BIT_W'(BUTTON_COUNT);
  localparam logic [sgp_pkg::BIT_W-1:0] PULSE_LAST = sgp_pkg::BIT_W'(CLOCK_PULSES);
  localparam logic [sgp_pkg::BIT_W-1:0] MARK_LAST  = sgp_pkg::BIT_W'(sgp_pkg::MARK_COUNT);
  localparam logic [sgp_pkg::TICK_W-1:0] TICK_ONE  = sgp_pkg::TICK_W'(1);

  sgp_pkg::sgp_phase_t                 phase_r, phase_nxt;
  logic [sgp_pkg::TICK_W-1:0]          tick_r, tick_nxt;
  logic [sgp_pkg::BIT_W-1:0]           bit_r, bit_nxt;
  logic                                clk_lvl_r, clk_lvl_nxt;
  logic                                lat_lvl_r, lat_lvl_nxt;
  logic [sgp_pkg::CODE_W-1:0]          pend_r, pend_nxt;
  logic [sgp_pkg::MARK_COUNT-1:0]      marks_r, marks_nxt;

  logic [sgp_pkg::TICK_W-1:0]          tick_inc;
  logic [sgp_pkg::TICK_W-1:0]          lat_dur;
  logic [sgp_pkg::TICK_W-1:0]          half_dur;
  logic [sgp_pkg::MARK_IDX_W-1:0]      mark_idx;
  logic [sgp_pkg::BIT_W-1:0]           bit_less;
  logic                                press_hit;
  logic                                done;
  logic                                anyp;
  logic [sgp_pkg::CODE_W-1:0]          code;

  // Durations of zero behave as one tick
  assign lat_dur  = {{(sgp_pkg::TICK_W-sgp_pkg::TIMING_W){1'b0}},
                     (cfg.latch_ticks == '0) ? sgp_pkg::TIMING_W'(1) : cfg.latch_ticks};
  assign half_dur = {{(sgp_pkg::TICK_W-sgp_pkg::TIMING_W){1'b0}},
                     (cfg.half_period_ticks == '0) ? sgp_pkg::TIMING_W'(1)
                                                   : cfg.half_period_ticks};
  assign tick_inc = tick_r + TICK_ONE;

  // Button marks are indexed by bit number minus one
  assign bit_less  = bit_r - sgp_pkg::BIT_W'(1);
  assign mark_idx  = bit_less[sgp_pkg::MARK_IDX_W-1:0];
  assign press_hit = !data_line && (bit_r >= sgp_pkg::BIT_W'(1)) &&
                     (bit_r <= BTN_LAST) && (bit_r <= MARK_LAST);

  // Advance the poll sequencer by one tick
  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    clk_lvl_nxt = clk_lvl_r;
    lat_lvl_nxt = lat_lvl_r;
    pend_nxt    = pend_r;
    marks_nxt   = marks_r;
    done        = 1'b0;
    anyp        = 1'b0;
    code        = '0;
    unique case (phase_r)
      sgp_pkg::PH_IDLE: begin
        if (poll_request) begin
          clk_lvl_nxt = 1'b1;
          lat_lvl_nxt = 1'b1;
          tick_nxt    = TICK_ONE;
          phase_nxt   = sgp_pkg::PH_LATCH;
        end
      end
      sgp_pkg::PH_LATCH: begin
        if ((tick_r >= lat_dur) || (tick_inc >= lat_dur)) begin
          lat_lvl_nxt = 1'b0;
          bit_nxt     = sgp_pkg::BIT_W'(1);
          tick_nxt    = TICK_ONE;
          phase_nxt   = sgp_pkg::PH_HIGH;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      sgp_pkg::PH_HIGH: begin
        tick_nxt = tick_inc;
        if (tick_inc >= half_dur) begin
          clk_lvl_nxt = 1'b0;
          tick_nxt    = TICK_ONE;
          phase_nxt   = sgp_pkg::PH_LOW;
        end
      end
      sgp_pkg::PH_LOW: begin
        tick_nxt = tick_inc;
        if (tick_inc >= half_dur) begin
          if (press_hit) begin
            if (marks_r[mark_idx]) begin
              // Armed press: disarm button; hold off unless zero
              marks_nxt = ~(sgp_pkg::MARK_COUNT'(1) << mark_idx);
              pend_nxt  = sgp_pkg::code_of_bit(bit_r);
              tick_nxt  = '0;
              phase_nxt = sgp_pkg::PH_HOLD;
              if (cfg.holdoff_ticks == '0) begin
                marks_nxt = '1;
                done      = 1'b1;
                anyp      = 1'b1;
                code      = sgp_pkg::code_of_bit(bit_r);
                phase_nxt = sgp_pkg::PH_IDLE;
              end
            end else begin
              done      = 1'b1;
              phase_nxt = sgp_pkg::PH_IDLE;
            end
          end else begin
            clk_lvl_nxt = 1'b1;
            if (bit_r >= PULSE_LAST) begin
              done      = 1'b1;
              phase_nxt = sgp_pkg::PH_IDLE;
            end else begin
              bit_nxt   = bit_r + sgp_pkg::BIT_W'(1);
              tick_nxt  = TICK_ONE;
              phase_nxt = sgp_pkg::PH_HIGH;
            end
          end
        end
      end
      sgp_pkg::PH_HOLD: begin
        tick_nxt = tick_inc;
        if (tick_inc >= cfg.holdoff_ticks) begin
          marks_nxt = '1;
          done      = 1'b1;
          anyp      = 1'b1;
          code      = pend_r;
          phase_nxt = sgp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = sgp_pkg::PH_IDLE;
      end
    endcase
  end

  // Hold state between accepted ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sgp_pkg::PH_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      clk_lvl_r <= 1'b0;
      lat_lvl_r <= 1'b0;
      pend_r    <= '0;
      marks_r   <= '1;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      lat_lvl_r <= lat_lvl_nxt;
      pend_r    <= pend_nxt;
      marks_r   <= marks_nxt;
    end
  end

  // Result of this tick, taken from the updated state
  always_comb begin
    res.clock_line  = clk_lvl_nxt;
    res.latch_line  = lat_lvl_nxt;
    res.poll_done   = done;
    res.button_code = code;
    res.any_pressed = anyp;
    res.busy_res    = (phase_nxt != sgp_pkg::PH_IDLE);
  end

  `SGP_ASSERT_IMP(a_marks_full_outside_hold, phase_r != sgp_pkg::PH_HOLD, marks_r == '1)
  `SGP_ASSERT_IMP(a_clock_low_in_hold, phase_r == sgp_pkg::PH_HOLD, !clk_lvl_r)
  `SGP_ASSERT_IMP(a_done_not_busy, step_en && done, !res.busy_res)
  `SGP_ASSERT_IMP(a_code_needs_press, step_en && (code != '0), anyp && done)

endmodule

`default_nettype wire

[sv/serial_gamepad_poller_unit.sv]
`default_nettype none

// Serial gamepad poller. Every accepted input item is one microsecond tick and
// yields exactly one result item: the pad clock and latch levels for that tick,
// a poll-done flag with the mapped button code and any_pressed, and busy. One
// item is taken per clock cycle while the sink takes results; the tick's work
// runs in one pass from the input through the poll sequencer into a single
// output register, so a result appears in the cycle after its item is accepted.
// in_tready is high unless that register holds a result the sink has not taken.
// Configuration (latch length, clock half period, hold-off) must be written via
// cfg only while no poll runs, unenforced here; no clearing pass after reset.

`include "serial_gamepad_poller_unit_macros.svh"

module serial_gamepad_poller_unit #(
  parameter int BUTTON_COUNT = 16,
  parameter int CLOCK_PULSES = 17
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [0] poll_request, [1] data_line, [7:2] zero
  input  wire logic [sgp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] clock_line, [1] latch_line, [2] poll_done, [5:3] button_code,
  // [6] any_pressed, [7] busy_res
  output logic [sgp_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_we,
  input  wire logic [sgp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sgp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  sgp_pkg::sgp_cfg_t     cfg_r;
  sgp_pkg::sgp_result_t  step_res;
  sgp_pkg::sgp_result_t  out_res_r;
  logic                  out_valid_r;
  logic                  in_acc;

  // Take a new item whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.latch_ticks       <= sgp_pkg::LATCH_TICKS_RST;
      cfg_r.half_period_ticks <= sgp_pkg::HALF_PERIOD_RST;
      cfg_r.holdoff_ticks     <= sgp_pkg::HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgp_pkg::CFG_LATCH_TICKS:
          cfg_r.latch_ticks <= cfg_wdata[sgp_pkg::TIMING_W-1:0];
        sgp_pkg::CFG_HALF_PERIOD:
          cfg_r.half_period_ticks <= cfg_wdata[sgp_pkg::TIMING_W-1:0];
        sgp_pkg::CFG_HOLDOFF_TICKS:
          cfg_r.holdoff_ticks <= cfg_wdata[sgp_pkg::TICK_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  sgp_core #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .CLOCK_PULSES (CLOCK_PULSES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (in_acc),
    .poll_request (in_tdata[0]),
    .data_line    (in_tdata[1]),
    .cfg          (cfg_r),
    .res          (step_res)
  );

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  `SGP_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_tready)
  `SGP_ASSERT_NXT(a_accept_fills_output, in_acc, out_valid_r)
  `SGP_ASSERT_IMP(a_press_means_done, out_valid_r && out_res_r.any_pressed,
                  out_res_r.poll_done && !out_res_r.busy_res)

endmodule

`default_nettype wire
